// ===== hdl/remapped_conv5x5_sampler_top_assert.svh =====
// Assertion macros shared by the sampler RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef REMAPPED_CONV5X5_SAMPLER_TOP_ASSERT_SVH
`define REMAPPED_CONV5X5_SAMPLER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define RCS_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rcs check failed");

// next-cycle implication, off during reset
`define RCS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rcs check failed");

`endif

// ===== hdl/rcs_pkg.sv =====
// Package for the remapped 5x5 convolution sampler: sizes, codes, types.
// Used by the top level; depends on nothing.
package rcs_pkg;

   localparam int MAX_ROWS    = 256;
   localparam int MAX_COLS    = 256;
   localparam int KERNEL_SIZE = 5;

   localparam int TAP_COUNT = KERNEL_SIZE * KERNEL_SIZE;
   localparam int RADIUS    = KERNEL_SIZE / 2;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int ADDR_W    = ROW_W + COL_W;
   localparam int IMG_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int TAP_W     = $clog2(TAP_COUNT);
   localparam int KPOS_W    = $clog2(KERNEL_SIZE);

   localparam int PIX_W    = 16;
   localparam int COEF_W   = 16;
   localparam int PROD_W   = PIX_W + 1 + COEF_W;
   localparam int BRIGHT_W = 37;
   localparam int DIM_W    = 9;
   localparam int LIM_W    = 17;

   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS = 1'd1;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

   typedef enum logic [1:0] {
      MODE_LOAD_PIXEL = 2'd0,
      MODE_LOAD_TAP   = 2'd1,
      MODE_SAMPLE     = 2'd2,
      MODE_UNUSED     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [7:0]         load_row;
      logic [7:0]         load_col;
      logic [PIX_W-1:0]   pixel_value;
      logic [4:0]         tap_index;
      logic signed [15:0] tap_value;
      logic signed [15:0] sample_row;
      logic signed [15:0] sample_col;
   } req_fields_type;

   function automatic req_fields_type unpack_req(input logic [REQ_DATA_W-1:0] d);
      req_fields_type f;
      f.load_row    = d[7:0];
      f.load_col    = d[15:8];
      f.pixel_value = d[31:16];
      f.tap_index   = d[36:32];
      f.tap_value   = d[52:37];
      f.sample_row  = d[68:53];
      f.sample_col  = d[84:69];
      return f;
   endfunction

endpackage

// ===== hdl/rcs_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// No dependencies; one read or write address per cycle.
module rcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/remapped_conv5x5_sampler_top.sv =====
// Remapped 5x5 convolution sampler, top level.
// Depends on rcs_pkg, rcs_ram and remapped_conv5x5_sampler_top_assert.svh.
//
// A pixel load or tap load returns nothing. A sample query whose 5x5 window crosses
// an image edge returns zero with the outside flag. An inside query makes 25 reads of
// the single-port image RAM, one per cycle, then passes the multiply and accumulate
// stages and the output load. The image RAM powers up undefined and needs no clearing
// pass; kernel taps reset to zero. The result register lets the next word in while a
// result still waits on rsp_tready.
module remapped_conv5x5_sampler_top
   import rcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // load_row, load_col, pixel_value, tap_index, tap_value, sample_row, sample_col, pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // brightness, pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // outside
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DIM_W-1:0]      csr_data
);

`include "remapped_conv5x5_sampler_top_assert.svh"

   state_type state_ff, state_in;

   logic [DIM_W-1:0] rows_ff, cols_ff;
   logic signed [COEF_W-1:0] taps_ff [TAP_COUNT];

   logic [ROW_W-1:0]  base_row_ff, base_row_in;
   logic [COL_W-1:0]  base_col_ff, base_col_in;
   logic [KPOS_W-1:0] dr_ff, dr_in, dc_ff, dc_in;
   logic [TAP_W-1:0]  cnt_ff, cnt_in;

   logic v1_ff, last1_ff, v2_ff, last2_ff;
   logic signed [COEF_W-1:0] tap1_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [BRIGHT_W-1:0] acc_ff, acc_in;
   logic out_flag_ff, out_flag_in;

   logic rsp_valid_ff;
   logic [BRIGHT_W-1:0] rsp_bright_ff;
   logic rsp_outside_ff;

   req_fields_type f;
   mode_type mode;
   logic accept, issue, last_issue, rsp_load;
   logic win_outside;
   logic [DIM_W-1:0] rows_eff, cols_eff;
   logic signed [LIM_W-1:0] lim_row, lim_col, row_x, col_x;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_addr;
   logic [PIX_W-1:0]     ram_rdata;
   logic [ROW_W-1:0]     rd_row;
   logic [COL_W-1:0]     rd_col;

   assign f      = unpack_req(req_tdata);
   assign mode   = mode_type'(req_tuser);
   assign accept = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign rows_eff = (rows_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_ff;
   assign cols_eff = (cols_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_ff;
   assign lim_row  = signed'(LIM_W'(rows_eff)) - signed'(LIM_W'(RADIUS));
   assign lim_col  = signed'(LIM_W'(cols_eff)) - signed'(LIM_W'(RADIUS));
   assign row_x    = LIM_W'(f.sample_row);
   assign col_x    = LIM_W'(f.sample_col);
   assign win_outside = (row_x < signed'(LIM_W'(RADIUS))) ||
                        (col_x < signed'(LIM_W'(RADIUS))) ||
                        (row_x >= lim_row) || (col_x >= lim_col);

   assign issue      = (state_ff == ST_RUN);
   assign last_issue = issue && (cnt_ff == TAP_W'(TAP_COUNT - 1));
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   assign ram_we = accept && (mode == MODE_LOAD_PIXEL) &&
                   (32'(f.load_row) < MAX_ROWS) && (32'(f.load_col) < MAX_COLS);
   assign rd_row = base_row_ff + ROW_W'(dr_ff);
   assign rd_col = base_col_ff + COL_W'(dc_ff);

   always_comb begin
      if (issue) begin
         ram_addr = {rd_row, rd_col};
      end else begin
         ram_addr = {f.load_row[ROW_W-1:0], f.load_col[COL_W-1:0]};
      end
   end

   rcs_ram #(
      .WIDTH(PIX_W),
      .DEPTH(IMG_DEPTH)
   ) u_image (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(f.pixel_value),
      .rdata(ram_rdata)
   );

   assign acc_in = acc_ff + BRIGHT_W'(prod_ff);

   always_comb begin
      state_in    = state_ff;
      base_row_in = base_row_ff;
      base_col_in = base_col_ff;
      dr_in       = dr_ff;
      dc_in       = dc_ff;
      cnt_in      = cnt_ff;
      out_flag_in = out_flag_ff;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept && (mode == MODE_SAMPLE)) begin
               base_row_in = f.sample_row[ROW_W-1:0] - ROW_W'(RADIUS);
               base_col_in = f.sample_col[COL_W-1:0] - COL_W'(RADIUS);
               dr_in       = '0;
               dc_in       = '0;
               cnt_in      = '0;
               out_flag_in = win_outside;
               state_in    = win_outside ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + TAP_W'(1);
            if (dc_ff == KPOS_W'(KERNEL_SIZE - 1)) begin
               dc_in = '0;
               dr_in = dr_ff + KPOS_W'(1);
            end else begin
               dc_in = dc_ff + KPOS_W'(1);
            end
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (v2_ff && last2_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= DIM_RESET;
         cols_ff      <= DIM_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         last1_ff     <= 1'b0;
         last2_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TAP_COUNT; i++) begin
            taps_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_ROWS: rows_ff <= csr_data;
               CSR_IMAGE_COLS: cols_ff <= csr_data;
               default: ;
            endcase
         end
         if (accept && (mode == MODE_LOAD_TAP) && (32'(f.tap_index) < TAP_COUNT)) begin
            taps_ff[f.tap_index[TAP_W-1:0]] <= f.tap_value;
         end
         v1_ff    <= issue;
         last1_ff <= last_issue;
         v2_ff    <= v1_ff;
         last2_ff <= last1_ff;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_row_ff <= base_row_in;
      base_col_ff <= base_col_in;
      dr_ff       <= dr_in;
      dc_ff       <= dc_in;
      cnt_ff      <= cnt_in;
      out_flag_ff <= out_flag_in;
      tap1_ff     <= taps_ff[cnt_ff];
      prod_ff     <= signed'({1'b0, ram_rdata}) * tap1_ff;
      if (accept && (mode == MODE_SAMPLE)) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_in;
      end
      if (rsp_load) begin
         rsp_bright_ff  <= out_flag_ff ? '0 : acc_ff;
         rsp_outside_ff <= out_flag_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_bright_ff);
   assign rsp_tuser  = rsp_outside_ff;

   `RCS_ASSERT_NEXT(a_drain_to_done, clock, reset, (v2_ff && last2_ff), (state_ff == ST_DONE))
   `RCS_ASSERT_NOW(a_outside_zero, clock, reset, (rsp_tvalid && rsp_tuser[0]), (rsp_tdata == '0))
   `RCS_ASSERT_NOW(a_no_write_busy, clock, reset, ram_we, (state_ff == ST_IDLE))
   `RCS_ASSERT_NEXT(a_edge_skip, clock, reset,
      (accept && (mode == MODE_SAMPLE) && win_outside), (state_ff == ST_DONE))
   `RCS_ASSERT_NOW(a_pipe_idle, clock, reset, (state_ff == ST_IDLE), (!v1_ff && !v2_ff))

endmodule
